FILE: design/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

  // List size and derived widths
  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream items
  localparam int CMD_W     = 4;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int ST_W      = 3;
  localparam int OUT_CNT_W = 5;

  localparam int IN_BITS      = CMD_W + DATA_W + POS_W;
  localparam int OUT_BITS     = DATA_W + ST_W + OUT_CNT_W + 2;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 4'd0,
    CMD_INS_LAST  = 4'd1,
    CMD_INS_AT    = 4'd2,
    CMD_DEL_FIRST = 4'd3,
    CMD_DEL_LAST  = 4'd4,
    CMD_DEL_VALUE = 4'd5,
    CMD_RD_FIRST  = 4'd6,
    CMD_RD_LAST   = 4'd7,
    CMD_RD_AT     = 4'd8
  } cmd_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_t;

  // What a cell loads in the next cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  // Per-cell control: update select plus the shared insert value / search key
  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

FILE: design/bole_cell.sv
// One list cell: holds an entry, shifts with its neighbors and compares against a key.
`timescale 1ns / 1ps

module bole_cell (
  input  logic                         clk,
  input  bole_pkg::cell_ctrl_t         ctrl,
  input  logic [bole_pkg::DATA_W-1:0]  left_value,
  input  logic [bole_pkg::DATA_W-1:0]  right_value,
  output logic [bole_pkg::DATA_W-1:0]  value,
  output logic                         match
);

  logic [bole_pkg::DATA_W-1:0] value_next;

  // Select the next entry: keep, take the new item, or shift from a neighbor
  always_comb begin
    case (ctrl.op)
      bole_pkg::CELL_HOLD:  value_next = value;
      bole_pkg::CELL_LOAD:  value_next = ctrl.data;
      bole_pkg::CELL_LEFT:  value_next = left_value;
      bole_pkg::CELL_RIGHT: value_next = right_value;
      default:              value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Compare the stored entry against the search key
  assign match = (value == ctrl.data);

endmodule

FILE: design/bounded_ordered_list_engine_unit.sv
// Top level of the bounded ordered list engine: command decode, cell chain, result register.
`timescale 1ns / 1ps

// Usage:
// - Commands enter on the s_ stream (tvalid/tready/tdata); each accepted item
//   yields exactly one result item on the m_ stream.
// - The list lives in a row of cells, one entry per cell. Inserts shift the
//   cells above the target one place up, removals shift them one place down,
//   and all cells compare against the search key in parallel, so each
//   command updates the whole list in the cycle it is accepted.
// - The result is registered and is on m_tdata in the cycle after the command is taken.
// - Throughput: one item per cycle while the receiver keeps m_tready high;
//   the rate is set by the cell update feeding the result register.
// - When the receiver stalls, the result register holds its item and s_tready
//   drops until that result is taken; s_tready follows m_tready combinationally.
// - Reset clears the count and the result valid flag; no clearing pass runs and
//   the block takes commands in the first cycle after reset. Entry contents
//   are undefined until written, but only entries below the count are read.
// - Errors (full, empty, bad position, not found, unknown command) return a
//   zero value and leave the list unchanged.

module bounded_ordered_list_engine_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // command[3:0], item_value[35:4], position[40:36], zero fill above
  input  logic [bole_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // result_value[31:0], status[34:32], entry_count[39:35], is_full[40],
  // is_empty[41], zero fill above
  output logic [bole_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int CAP = bole_pkg::CAPACITY;

  // Input fields
  logic [bole_pkg::CMD_W-1:0]  cmd;
  logic [bole_pkg::DATA_W-1:0] item_value;
  logic [bole_pkg::POS_W-1:0]  position;
  logic                        fire;

  assign cmd        = s_tdata[bole_pkg::CMD_W-1:0];
  assign item_value = s_tdata[bole_pkg::CMD_W +: bole_pkg::DATA_W];
  assign position   = s_tdata[bole_pkg::CMD_W + bole_pkg::DATA_W +: bole_pkg::POS_W];
  assign s_tready   = !m_tvalid || m_tready;
  assign fire       = s_tvalid && s_tready;

  // State registers
  logic [bole_pkg::CNT_W-1:0]  count;
  logic [bole_pkg::CNT_W-1:0]  count_next;

  // Cell chain signals
  bole_pkg::cell_ctrl_t        ctrl [CAP];
  logic [bole_pkg::DATA_W-1:0] cell_q [CAP];
  logic [CAP-1:0]              match_raw;
  logic [CAP-1:0]              live;
  logic [CAP-1:0]              hit;
  logic [CAP-1:0]              first_hit;
  logic [bole_pkg::IDX_W-1:0]  hit_idx;

  // Decode results
  logic                        do_ins;
  logic                        do_del;
  logic                        do_rd;
  logic [bole_pkg::IDX_W-1:0]  tgt;
  bole_pkg::status_t           st;
  logic [bole_pkg::DATA_W-1:0] res;

  // Output register
  logic [bole_pkg::DATA_W-1:0]    out_value;
  bole_pkg::status_t              out_status;
  logic [bole_pkg::OUT_CNT_W-1:0] out_count;
  logic                           out_full;
  logic                           out_empty;

  // Find the first live entry equal to the key
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      live[i] = (i < int'(count));
    end
  end

  assign hit       = match_raw & live;
  assign first_hit = hit & (~hit + 1'b1);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | bole_pkg::IDX_W'(i);
      end
    end
  end

  // Decode the command into a target cell, a shift direction and a status
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_rd      = 1'b0;
    tgt        = '0;
    st         = bole_pkg::ST_OK;
    count_next = count;
    case (bole_pkg::cmd_t'(cmd))
      bole_pkg::CMD_INS_FIRST, bole_pkg::CMD_INS_LAST, bole_pkg::CMD_INS_AT: begin
        if (int'(count) >= CAP) begin
          st = bole_pkg::ST_FULL;
        end else if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_INS_AT &&
                     (int'(position) < 1 || int'(position) > int'(count) + 1)) begin
          st = bole_pkg::ST_BADPOS;
        end else begin
          do_ins     = 1'b1;
          count_next = count + 1'b1;
          if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_INS_LAST) begin
            tgt = bole_pkg::IDX_W'(count);
          end else if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_INS_AT) begin
            tgt = bole_pkg::IDX_W'(position - 1'b1);
          end
        end
      end
      bole_pkg::CMD_DEL_FIRST, bole_pkg::CMD_DEL_LAST, bole_pkg::CMD_DEL_VALUE: begin
        if (count == '0) begin
          st = bole_pkg::ST_EMPTY;
        end else if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_DEL_VALUE && !(|hit)) begin
          st = bole_pkg::ST_NOTFOUND;
        end else begin
          do_del     = 1'b1;
          count_next = count - 1'b1;
          if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_DEL_LAST) begin
            tgt = bole_pkg::IDX_W'(count - 1'b1);
          end else if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_DEL_VALUE) begin
            tgt = hit_idx;
          end
        end
      end
      bole_pkg::CMD_RD_FIRST, bole_pkg::CMD_RD_LAST, bole_pkg::CMD_RD_AT: begin
        if (count == '0) begin
          st = bole_pkg::ST_EMPTY;
        end else if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_RD_AT &&
                     (int'(position) < 1 || int'(position) > int'(count))) begin
          st = bole_pkg::ST_BADPOS;
        end else begin
          do_rd = 1'b1;
          if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_RD_LAST) begin
            tgt = bole_pkg::IDX_W'(count - 1'b1);
          end else if (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_RD_AT) begin
            tgt = bole_pkg::IDX_W'(position - 1'b1);
          end
        end
      end
      default: begin
        st = bole_pkg::ST_UNKNOWN;
      end
    endcase
  end

  // Pick the entry that is read or removed
  assign res = (do_del || do_rd) ? cell_q[tgt] : '0;

  // Drive cells: load at the target, shift above it (at and above it on removal), else hold
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ctrl[i].data = item_value;
      if (fire && do_ins && bole_pkg::IDX_W'(i) == tgt) begin
        ctrl[i].op = bole_pkg::CELL_LOAD;
      end else if (fire && do_ins && bole_pkg::IDX_W'(i) > tgt) begin
        ctrl[i].op = bole_pkg::CELL_LEFT;
      end else if (fire && do_del && bole_pkg::IDX_W'(i) >= tgt) begin
        ctrl[i].op = bole_pkg::CELL_RIGHT;
      end else begin
        ctrl[i].op = bole_pkg::CELL_HOLD;
      end
    end
  end

  // Row of cells, each wired to its two neighbors
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [bole_pkg::DATA_W-1:0] left_in;
    logic [bole_pkg::DATA_W-1:0] right_in;

    if (g == 0) begin : g_head
      assign left_in = item_value;
    end else begin : g_mid_l
      assign left_in = cell_q[g-1];
    end

    if (g == CAP - 1) begin : g_tail
      assign right_in = cell_q[g];
    end else begin : g_mid_r
      assign right_in = cell_q[g+1];
    end

    bole_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[g]),
      .left_value  (left_in),
      .right_value (right_in),
      .value       (cell_q[g]),
      .match       (match_raw[g])
    );
  end

  // Update the count on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value  <= res;
      out_status <= st;
      out_count  <= bole_pkg::OUT_CNT_W'(count_next);
      out_full   <= (int'(count_next) == CAP);
      out_empty  <= (count_next == '0);
    end
  end

  assign m_tdata = bole_pkg::OUT_TDATA_W'({out_empty, out_full, out_count, out_status,
                                           out_value});

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAP)
    else $error("list count above capacity");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("accepted item produced no result");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != bole_pkg::ST_OK) |-> (out_value == '0))
    else $error("error result carries a nonzero value");

  a_full_status_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == bole_pkg::ST_FULL) |-> out_full)
    else $error("full status without full flag");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_full && out_empty))
    else $error("full and empty flags both set");

endmodule
